[src/vem_pkg.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor package
// Shared types, codes and saturating arithmetic helpers for the monitor.
// ---------------------------------------------------------------------------
package vem_pkg;

   // Request operation codes. Code 3 is unused and leaves the state alone.
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_CLEAR  = 2'd2
   } vem_op_type;

   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned STAT_W  = 32;
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned DATA_W  = 32;

   // Register indexes, taken from paddr[2].
   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;

   localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

   // Threshold settings.
   typedef struct packed {
      logic [LIMIT_W-1:0] upper;
      logic [LIMIT_W-1:0] lower;
   } vem_cfg_type;

   // Bookkeeping of one side (over or under).
   typedef struct packed {
      logic              open;
      logic [STAT_W-1:0] run;
      logic [STAT_W-1:0] count;
      logic [STAT_W-1:0] sum;
      logic [STAT_W-1:0] max;
   } vem_side_type;

   typedef struct packed {
      vem_side_type over;
      vem_side_type under;
   } vem_state_type;

   // One result item.
   typedef struct packed {
      logic [STAT_W-1:0] over_events;
      logic [STAT_W-1:0] under_events;
      logic [STAT_W-1:0] over_total_ms;
      logic [STAT_W-1:0] under_total_ms;
      logic [STAT_W-1:0] over_longest_ms;
      logic [STAT_W-1:0] under_longest_ms;
   } vem_result_type;

   // Increment that stops at the all-ones value.
   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] a);
      return (a == STAT_MAX) ? a : a + {{(STAT_W-1){1'b0}}, 1'b1};
   endfunction

   // Addition that stops at the all-ones value.
   function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                 input logic [STAT_W-1:0] b);
      logic [STAT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[STAT_W] ? STAT_MAX : s[STAT_W-1:0];
   endfunction

   // A sample beyond the limit opens an excursion; otherwise any open one closes.
   function automatic vem_side_type side_sample(input vem_side_type cur,
                                                input logic beyond);
      vem_side_type    nxt;
      logic [STAT_W-1:0] len;
      nxt = cur;
      len = cur.open ? cur.run : '0;
      if (beyond) begin
         if (!cur.open) begin
            nxt.open  = 1'b1;
            nxt.run   = '0;
            nxt.count = sat_inc(cur.count);
         end
      end else begin
         nxt.open = 1'b0;
         nxt.run  = '0;
         nxt.sum  = sat_add(cur.sum, len);
         if (len > cur.max) begin
            nxt.max = len;
         end
      end
      return nxt;
   endfunction

   // A tick lengthens an open excursion.
   function automatic vem_side_type side_tick(input vem_side_type cur);
      vem_side_type nxt;
      nxt = cur;
      if (cur.open) begin
         nxt.run = sat_inc(cur.run);
      end
      return nxt;
   endfunction

endpackage

[src/vem_if.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor channels
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------

// Request channel: operation code and voltage sample.
interface vem_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     op;
   logic [vem_pkg::LIMIT_W-1:0]    voltage;

   modport source (output valid, output op, output voltage, input ready);
   modport sink (input valid, input op, input voltage, output ready);
endinterface

// Result channel: counts, totals and maxima of both sides.
interface vem_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vem_pkg::STAT_W-1:0]    over_events;
   logic [vem_pkg::STAT_W-1:0]    under_events;
   logic [vem_pkg::STAT_W-1:0]    over_total_ms;
   logic [vem_pkg::STAT_W-1:0]    under_total_ms;
   logic [vem_pkg::STAT_W-1:0]    over_longest_ms;
   logic [vem_pkg::STAT_W-1:0]    under_longest_ms;

   modport source (output valid, output over_events, output under_events,
                   output over_total_ms, output under_total_ms,
                   output over_longest_ms, output under_longest_ms, input ready);
   modport sink (input valid, input over_events, input under_events,
                 input over_total_ms, input under_total_ms,
                 input over_longest_ms, input under_longest_ms, output ready);
endinterface

[src/voltage_excursion_monitor_top.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor
// Counts and times over- and under-voltage excursions of a sample stream.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_chan: op selects a voltage sample, a one
//   millisecond tick or a clear of all statistics. Every request yields
//   exactly one result on rsp_chan with both event counts, both totals and
//   both maxima, each saturating at 32 bits and including an open run.
//   Thresholds are set over the APB-style port (upper at 0, lower at 4);
//   a threshold of zero disables its side. Write them only while idle.
//   A taken request is held in the input register, is applied to the state
//   in the update stage and then loads the output register with its result.
//   Throughput: one request per cycle while rsp_chan.ready is high, set by
//   the single state update per request and the single output register.
//   Reset clears thresholds, statistics and all valid flags.
//   When the receiver stalls, the input register and the update stage
//   still fill, so up to three requests are held before req_chan.ready
//   drops.
// ---------------------------------------------------------------------------
module voltage_excursion_monitor_top (
   input  logic                          clock,
   input  logic                          reset,
   vem_req_if.sink                       req_chan,
   vem_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vem_pkg::ADDR_W-1:0]    paddr,
   input  logic [vem_pkg::DATA_W-1:0]    pwdata,
   output logic [vem_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   vem_pkg::vem_cfg_type        cfg;
   vem_pkg::vem_state_type      state;
   logic                        in_valid_ff, in_valid_in;
   logic [1:0]                  in_op_ff;
   logic [vem_pkg::LIMIT_W-1:0] in_voltage_ff;
   logic                        upd_valid_ff, upd_valid_in;
   logic                        out_free;
   logic                        upd_move;
   logic                        upd_free;
   logic                        in_move;
   logic                        in_free;
   logic                        req_take;

   vem_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Pipeline flow: each stage moves when the one after it has room.
   assign upd_move = upd_valid_ff && out_free;
   assign upd_free = !upd_valid_ff || upd_move;
   assign in_move  = in_valid_ff && upd_free;
   assign in_free  = !in_valid_ff || in_move;
   assign req_take = req_chan.valid && in_free;

   assign req_chan.ready = in_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      upd_valid_in = upd_valid_ff;
      if (in_move) begin
         upd_valid_in = 1'b1;
      end else if (upd_move) begin
         upd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         upd_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         upd_valid_ff <= upd_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_chan.op;
         in_voltage_ff <= req_chan.voltage;
      end
   end

   vem_state u_state (
      .clock   (clock),
      .reset   (reset),
      .update  (in_move),
      .op      (in_op_ff),
      .voltage (in_voltage_ff),
      .cfg     (cfg),
      .state   (state)
   );

   vem_result u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (upd_move),
      .state    (state),
      .out_free (out_free),
      .rsp      (rsp_chan)
   );

   // The state changes only when a request enters the update stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !in_move |=> $stable(state))
      else $error("state changed without a request");

   // A stalled update stage keeps its request.
   a_upd_hold: assert property (@(posedge clock) disable iff (reset)
      upd_valid_ff && !out_free |=> upd_valid_ff)
      else $error("update stage dropped a stalled request");

   // A load always presents a result.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      upd_move |=> rsp_chan.valid)
      else $error("loaded result not presented");

   // A closed side carries no run length.
   a_over_run: assert property (@(posedge clock) disable iff (reset)
      !state.over.open |-> state.over.run == '0)
      else $error("over run nonzero while closed");

   a_under_run: assert property (@(posedge clock) disable iff (reset)
      !state.under.open |-> state.under.run == '0)
      else $error("under run nonzero while closed");

endmodule

[src/vem_csr.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor register file
// APB-style access to the upper and lower thresholds.
// ---------------------------------------------------------------------------
module vem_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vem_pkg::ADDR_W-1:0]    paddr,
   input  logic [vem_pkg::DATA_W-1:0]    pwdata,
   output logic [vem_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output vem_pkg::vem_cfg_type          cfg
);

   logic                         write_en;
   logic [vem_pkg::LIMIT_W-1:0]  upper_ff, upper_in;
   logic [vem_pkg::LIMIT_W-1:0]  lower_ff, lower_in;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   // Next threshold values on a write access.
   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (write_en) begin
         case (paddr[2])
            vem_pkg::REG_UPPER: upper_in = pwdata[vem_pkg::LIMIT_W-1:0];
            vem_pkg::REG_LOWER: lower_in = pwdata[vem_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= '0;
         lower_ff <= '0;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   // Read data.
   always_comb begin
      case (paddr[2])
         vem_pkg::REG_UPPER: prdata = {{(vem_pkg::DATA_W-vem_pkg::LIMIT_W){1'b0}}, upper_ff};
         vem_pkg::REG_LOWER: prdata = {{(vem_pkg::DATA_W-vem_pkg::LIMIT_W){1'b0}}, lower_ff};
         default:            prdata = '0;
      endcase
   end

   assign cfg.upper = upper_ff;
   assign cfg.lower = lower_ff;

endmodule

[src/vem_state.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor state
// Excursion bookkeeping of both sides, updated once per request.
// ---------------------------------------------------------------------------
module vem_state (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic [1:0]                    op,
   input  logic [vem_pkg::LIMIT_W-1:0]   voltage,
   input  vem_pkg::vem_cfg_type          cfg,
   output vem_pkg::vem_state_type        state
);

   vem_pkg::vem_state_type state_ff, state_in;
   logic                   upper_on;
   logic                   lower_on;

   assign upper_on = (cfg.upper != '0);
   assign lower_on = (cfg.lower != '0);

   // Apply one request to the state.
   always_comb begin
      state_in = state_ff;
      if (update) begin
         case (op)
            vem_pkg::OP_SAMPLE: begin
               if (upper_on) begin
                  state_in.over = vem_pkg::side_sample(state_ff.over, voltage > cfg.upper);
               end
               if (lower_on) begin
                  state_in.under = vem_pkg::side_sample(state_ff.under, voltage < cfg.lower);
               end
            end
            vem_pkg::OP_TICK: begin
               state_in.over  = vem_pkg::side_tick(state_ff.over);
               state_in.under = vem_pkg::side_tick(state_ff.under);
            end
            vem_pkg::OP_CLEAR: state_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

[src/vem_result.sv]
// ---------------------------------------------------------------------------
// Voltage excursion monitor result stage
// Forms totals and maxima including open runs into the output register.
// ---------------------------------------------------------------------------
module vem_result (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  vem_pkg::vem_state_type   state,
   output logic                     out_free,
   vem_rsp_if.source                rsp
);

   logic                       valid_ff, valid_in;
   vem_pkg::vem_result_type    result_ff, result_in;
   logic [vem_pkg::STAT_W-1:0] orun;
   logic [vem_pkg::STAT_W-1:0] urun;

   assign out_free = !valid_ff || rsp.ready;

   // Result values from the state after the request.
   always_comb begin
      orun = state.over.open  ? state.over.run  : '0;
      urun = state.under.open ? state.under.run : '0;
      result_in.over_events      = state.over.count;
      result_in.under_events     = state.under.count;
      result_in.over_total_ms    = vem_pkg::sat_add(state.over.sum, orun);
      result_in.under_total_ms   = vem_pkg::sat_add(state.under.sum, urun);
      result_in.over_longest_ms  = (orun > state.over.max)  ? orun : state.over.max;
      result_in.under_longest_ms = (urun > state.under.max) ? urun : state.under.max;
   end

   // Output valid: set by a load, cleared when taken.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.over_events      = result_ff.over_events;
   assign rsp.under_events     = result_ff.under_events;
   assign rsp.over_total_ms    = result_ff.over_total_ms;
   assign rsp.under_total_ms   = result_ff.under_total_ms;
   assign rsp.over_longest_ms  = result_ff.over_longest_ms;
   assign rsp.under_longest_ms = result_ff.under_longest_ms;

endmodule
